// ===== rtl/core/eare_pkg.sv =====
package eare_pkg;

  // Field widths
  localparam int CNT_W      = 32;
  localparam int CPR_W      = 25;
  localparam int GAIN_W     = 17;
  localparam int ANGLE_W    = 24;
  localparam int RATE_W     = 41;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Offset from upright needs one bit more than the count
  localparam int MOD_W = CNT_W + 1;

  // Defaults for the top level parameters
  localparam int RATE_FRAC_BITS_DEF = 16;
  localparam int TIME_BITS_DEF      = 48;

  // Gain is Q1.16
  localparam int GAIN_FRAC = 16;

  localparam logic [CPR_W-1:0]  CPR_MAX    = CPR_W'(16777216);
  localparam logic [CPR_W-1:0]  CPR_RESET  = CPR_W'(4096);
  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CPR     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT = CFG_IDX_W'(2);

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_NOT_INIT = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_BAD_STEP = STATUS_W'(2);

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CHECK,
    CMD_STEP_MOD,
    CMD_ANGLE,
    CMD_LOAD_MOD2,
    CMD_DELTA,
    CMD_LOAD_DIV,
    CMD_STEP_DIV,
    CMD_RAW,
    CMD_LOAD_MUL,
    CMD_STEP_MUL,
    CMD_ADJ,
    CMD_COMMIT
  } dp_cmd_e;

  typedef struct packed {
    logic err;   // item answers with an error status
    logic op;    // latched op of the current item
    logic last;  // iterative unit is on its final step
  } dp_stat_t;

endpackage

// ===== rtl/core/eare_dp.sv =====
module eare_dp #(
  parameter int RateFracBits = 16,
  parameter int TimeBits     = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  eare_pkg::dp_cmd_e                    cmd_i,
  output eare_pkg::dp_stat_t                   stat_o,
  input  logic                                 cfg_valid_i,
  input  logic [eare_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [eare_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 op_i,
  input  logic signed [eare_pkg::CNT_W-1:0]    count_i,
  input  logic [TimeBits-1:0]                  timestamp_i,
  output logic signed [eare_pkg::ANGLE_W-1:0]  angle_counts_o,
  output logic signed [eare_pkg::RATE_W-1:0]   rate_o,
  output logic [eare_pkg::STATUS_W-1:0]        status_o
);
  import eare_pkg::*;

  // Divider: numerator 2*|delta|*2^F + dt, denominator 2*dt
  localparam int MagW  = ANGLE_W + RateFracBits;
  localparam int QB    = MagW;
  localparam int NW    = ((MagW + 1 > TimeBits) ? MagW + 1 : TimeBits) + 1;
  localparam int DW    = TimeBits + 1;
  localparam int QX    = (QB + 1 > RATE_W + 1) ? QB + 1 : RATE_W + 1;
  localparam int AccW  = RATE_W + GAIN_W;
  localparam int ItMax = (MOD_W > QB) ? ((MOD_W > GAIN_W) ? MOD_W : GAIN_W)
                                      : ((QB > GAIN_W) ? QB : GAIN_W);
  localparam int IterW = $clog2(ItMax + 1);

  localparam logic [QX-1:0]     NegLim   = QX'(1) << (RATE_W - 1);
  localparam logic [QX-1:0]     PosLim   = NegLim - QX'(1);
  localparam logic [RATE_W-1:0] RateMax  = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W-1:0] RateMin  = {1'b1, {(RATE_W-1){1'b0}}};
  localparam logic [AccW-1:0]   RoundAdd = AccW'(1) << (GAIN_FRAC - 1);

  // Configuration
  logic [CPR_W-1:0]  cpr_q;
  logic [GAIN_W-1:0] gain_q;
  logic [CNT_W-1:0]  upright_q;
  logic [CPR_W-1:0]  cpr_wr;
  logic [GAIN_W-1:0] gain_wr;

  // Estimator state
  logic                ready_q;
  logic [ANGLE_W-1:0]  last_angle_q;
  logic [TimeBits-1:0] last_time_q;
  logic [RATE_W-1:0]   sm_q;

  // Current item
  logic                op_q;
  logic [CNT_W-1:0]    count_q;
  logic [TimeBits-1:0] ts_q;
  logic [STATUS_W-1:0] err_now;

  // Iteration counter shared by the three units
  logic [IterW-1:0] it_q;

  // Modulo unit
  logic             mod_neg_q;
  logic [MOD_W-1:0] mod_mag_q;
  logic [CPR_W-1:0] mod_rem_q;
  logic [MOD_W-1:0] mod_opnd;
  logic [MOD_W-1:0] mod_mag_ld;
  logic [CPR_W:0]   mod_trial;
  logic [CPR_W-1:0] half;
  logic [CPR_W:0]   wrap_val;

  logic [ANGLE_W-1:0] angle_q;
  logic [ANGLE_W-1:0] delta_q;

  // Divider
  logic [ANGLE_W-1:0]  dmag;
  logic [MagW-1:0]     num_mag;
  logic [TimeBits-1:0] dt;
  logic [NW-1:0]       n_full;
  logic                div_neg_q;
  logic [DW-1:0]       div_rem_q;
  logic [DW-1:0]       div_den_q;
  logic [QB-1:0]       div_quo_q;
  logic [DW:0]         div_trial;
  logic                div_ge;
  logic [QX-1:0]       quo_ext;
  logic [RATE_W-1:0]   raw_sat;
  logic [RATE_W-1:0]   raw_q;

  // Multiplier
  logic [RATE_W:0]     diff;
  logic                mul_neg_q;
  logic [RATE_W-1:0]   mul_mag_q;
  logic [GAIN_W-1:0]   mul_gain_q;
  logic [AccW-1:0]     acc_q;
  logic [AccW-1:0]     acc_rnd;
  logic [RATE_W:0]     adj_q;
  logic [RATE_W:0]     new_sm;

  always_comb begin
    cpr_wr = cfg_data_i[CPR_W-1:0];
    if (cpr_wr == '0) begin
      cpr_wr = CPR_W'(1);
    end else if (cpr_wr > CPR_MAX) begin
      cpr_wr = CPR_MAX;
    end
    gain_wr = cfg_data_i[GAIN_W-1:0];
    if (gain_wr > GAIN_ONE) begin
      gain_wr = GAIN_ONE;
    end
  end

  always_comb begin
    if (op_q && !ready_q) begin
      err_now = STATUS_NOT_INIT;
    end else if (op_q && (ts_q <= last_time_q)) begin
      err_now = STATUS_BAD_STEP;
    end else begin
      err_now = STATUS_OK;
    end
  end

  assign stat_o.err  = (err_now != STATUS_OK);
  assign stat_o.op   = op_q;
  assign stat_o.last = (it_q == IterW'(1));

  // Modulo: operand is the offset from upright, or the change of angle
  always_comb begin
    if (cmd_i == CMD_CHECK) begin
      mod_opnd = {count_q[CNT_W-1], count_q} - {upright_q[CNT_W-1], upright_q};
    end else begin
      mod_opnd = {{(MOD_W-ANGLE_W){angle_q[ANGLE_W-1]}}, angle_q}
               - {{(MOD_W-ANGLE_W){last_angle_q[ANGLE_W-1]}}, last_angle_q};
    end
    mod_mag_ld = mod_opnd[MOD_W-1] ? -mod_opnd : mod_opnd;
    mod_trial  = {mod_rem_q, mod_mag_q[MOD_W-1]};
  end

  // Truncating remainder carries the sign of the operand, then wrap into [-half, half) for an even modulus.
  // A zero remainder takes the non-negative path, so modulus one wraps to -1.
  always_comb begin
    half = cpr_q >> 1;
    if (!mod_neg_q || (mod_rem_q == '0)) begin
      if (mod_rem_q >= half) begin
        wrap_val = {1'b0, mod_rem_q} - {1'b0, cpr_q};
      end else begin
        wrap_val = {1'b0, mod_rem_q};
      end
    end else begin
      if (mod_rem_q > half) begin
        wrap_val = {1'b0, cpr_q} - {1'b0, mod_rem_q};
      end else begin
        wrap_val = -{1'b0, mod_rem_q};
      end
    end
  end

  always_comb begin
    dmag      = delta_q[ANGLE_W-1] ? -delta_q : delta_q;
    num_mag   = {dmag, {RateFracBits{1'b0}}};
    dt        = ts_q - last_time_q;
    n_full    = NW'({num_mag, 1'b0}) + NW'(dt);
    div_trial = {div_rem_q, div_quo_q[QB-1]};
    div_ge    = (div_trial >= {1'b0, div_den_q});
  end

  always_comb begin
    quo_ext = QX'(div_quo_q);
    if (!div_neg_q) begin
      raw_sat = (quo_ext > PosLim) ? RateMax : quo_ext[RATE_W-1:0];
    end else begin
      raw_sat = (quo_ext > NegLim) ? RateMin : -quo_ext[RATE_W-1:0];
    end
  end

  always_comb begin
    diff    = {raw_q[RATE_W-1], raw_q} - {sm_q[RATE_W-1], sm_q};
    acc_rnd = (acc_q + RoundAdd) >> GAIN_FRAC;
    new_sm  = {sm_q[RATE_W-1], sm_q} + adj_q;
  end

  // Control, configuration and estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q        <= CPR_RESET;
      gain_q       <= GAIN_RESET;
      upright_q    <= '0;
      ready_q      <= 1'b0;
      last_angle_q <= '0;
      last_time_q  <= '0;
      sm_q         <= '0;
      it_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_CPR:     cpr_q     <= cpr_wr;
          CFG_GAIN:    gain_q    <= gain_wr;
          CFG_UPRIGHT: upright_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      unique case (cmd_i) inside
        CMD_CHECK, CMD_LOAD_MOD2: it_q <= IterW'(MOD_W);
        CMD_LOAD_DIV:             it_q <= IterW'(QB);
        CMD_LOAD_MUL:             it_q <= IterW'(GAIN_W);
        CMD_STEP_MOD, CMD_STEP_DIV, CMD_STEP_MUL: it_q <= it_q - IterW'(1);
        CMD_COMMIT: begin
          if (err_now == STATUS_OK) begin
            ready_q      <= 1'b1;
            last_angle_q <= angle_q;
            last_time_q  <= ts_q;
            sm_q         <= op_q ? new_sm[RATE_W-1:0] : '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i) inside
      CMD_LOAD: begin
        op_q    <= op_i;
        count_q <= count_i;
        ts_q    <= timestamp_i;
      end
      CMD_CHECK, CMD_LOAD_MOD2: begin
        mod_neg_q <= mod_opnd[MOD_W-1];
        mod_mag_q <= mod_mag_ld;
        mod_rem_q <= '0;
      end
      CMD_STEP_MOD: begin
        mod_mag_q <= {mod_mag_q[MOD_W-2:0], 1'b0};
        if (mod_trial >= {1'b0, cpr_q}) begin
          mod_rem_q <= CPR_W'(mod_trial - {1'b0, cpr_q});
        end else begin
          mod_rem_q <= mod_trial[CPR_W-1:0];
        end
      end
      CMD_ANGLE: angle_q <= wrap_val[ANGLE_W-1:0];
      CMD_DELTA: delta_q <= wrap_val[ANGLE_W-1:0];
      CMD_LOAD_DIV: begin
        div_neg_q <= delta_q[ANGLE_W-1];
        div_rem_q <= DW'(n_full >> QB);
        div_quo_q <= n_full[QB-1:0];
        div_den_q <= {dt, 1'b0};
      end
      CMD_STEP_DIV: begin
        div_rem_q <= div_ge ? DW'(div_trial - {1'b0, div_den_q}) : div_trial[DW-1:0];
        div_quo_q <= {div_quo_q[QB-2:0], div_ge};
      end
      CMD_RAW: raw_q <= raw_sat;
      CMD_LOAD_MUL: begin
        mul_neg_q  <= diff[RATE_W];
        mul_mag_q  <= diff[RATE_W] ? RATE_W'(-diff) : diff[RATE_W-1:0];
        mul_gain_q <= gain_q;
        acc_q      <= '0;
      end
      CMD_STEP_MUL: begin
        acc_q      <= {acc_q[AccW-2:0], 1'b0}
                    + (mul_gain_q[GAIN_W-1] ? AccW'(mul_mag_q) : AccW'(0));
        mul_gain_q <= {mul_gain_q[GAIN_W-2:0], 1'b0};
      end
      CMD_ADJ: begin
        adj_q <= mul_neg_q ? -{1'b0, acc_rnd[RATE_W-1:0]} : {1'b0, acc_rnd[RATE_W-1:0]};
      end
      CMD_COMMIT: begin
        status_o <= err_now;
        if (err_now != STATUS_OK) begin
          angle_counts_o <= '0;
          rate_o         <= '0;
        end else begin
          angle_counts_o <= angle_q;
          rate_o         <= op_q ? new_sm[RATE_W-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/eare_ctrl.sv =====
module eare_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  eare_pkg::dp_stat_t  stat_i,
  output eare_pkg::dp_cmd_e   cmd_o
);
  import eare_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD1,
    ST_ANGLE,
    ST_LD_MOD2,
    ST_MOD2,
    ST_DELTA,
    ST_LD_DIV,
    ST_DIV,
    ST_RAW,
    ST_LD_MUL,
    ST_MUL,
    ST_ADJ,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o   = CMD_CHECK;
        state_d = stat_i.err ? ST_FINISH : ST_MOD1;
      end
      ST_MOD1: begin
        cmd_o = CMD_STEP_MOD;
        if (stat_i.last) state_d = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd_o   = CMD_ANGLE;
        state_d = stat_i.op ? ST_LD_MOD2 : ST_FINISH;
      end
      ST_LD_MOD2: begin
        cmd_o   = CMD_LOAD_MOD2;
        state_d = ST_MOD2;
      end
      ST_MOD2: begin
        cmd_o = CMD_STEP_MOD;
        if (stat_i.last) state_d = ST_DELTA;
      end
      ST_DELTA: begin
        cmd_o   = CMD_DELTA;
        state_d = ST_LD_DIV;
      end
      ST_LD_DIV: begin
        cmd_o   = CMD_LOAD_DIV;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o = CMD_STEP_DIV;
        if (stat_i.last) state_d = ST_RAW;
      end
      ST_RAW: begin
        cmd_o   = CMD_RAW;
        state_d = ST_LD_MUL;
      end
      ST_LD_MUL: begin
        cmd_o   = CMD_LOAD_MUL;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o = CMD_STEP_MUL;
        if (stat_i.last) state_d = ST_ADJ;
      end
      ST_ADJ: begin
        cmd_o   = CMD_ADJ;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd_o   = CMD_COMMIT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o == CMD_COMMIT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/encoder_angle_rate_estimator.sv =====
// Encoder angle and rate estimator.
// Input channel (in_valid_i/in_ready_o) takes one item: op_i, count_i, timestamp_i.
// Op 0 sets the reference angle and time and clears the rate; op 1 updates the
// filtered rate. Output channel (out_valid_o/out_ready_i) returns one item per
// input item: angle_counts_o, rate_o (Q RateFracBits counts per tick), status_o.
// Configuration writes go over cfg_valid_i/cfg_index_i/cfg_data_i, always ready,
// and are meant to happen while no item is in flight.
// An error status goes from the check straight to the result write; an init
// runs one modulo pass, and an update runs two modulo passes, the divider and
// the multiplier. The two 33-step modulo passes, the radix-2 divider and the
// 17-step shift-add gain multiplier all share one iteration counter, so one item
// is worked on at a time; the next item is taken the cycle after the result is
// written to the output register.
// If the receiver stalls, the result waits in the output register; the next
// item is accepted and processed meanwhile, and holds before its result write.
// Reset clears the init flag, the stored angle, time and rate, and restores the
// default configuration (4096 counts per turn, gain 0.25, upright count 0).
module encoder_angle_rate_estimator #(
  parameter int RateFracBits = eare_pkg::RATE_FRAC_BITS_DEF,
  parameter int TimeBits     = eare_pkg::TIME_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic signed [eare_pkg::CNT_W-1:0]   count_i,
  input  logic [TimeBits-1:0]                 timestamp_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [eare_pkg::ANGLE_W-1:0] angle_counts_o,
  output logic signed [eare_pkg::RATE_W-1:0]  rate_o,
  output logic [eare_pkg::STATUS_W-1:0]       status_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [eare_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [eare_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import eare_pkg::*;

  dp_cmd_e  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  eare_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  eare_dp #(
    .RateFracBits (RateFracBits),
    .TimeBits     (TimeBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .count_i        (count_i),
    .timestamp_i    (timestamp_i),
    .angle_counts_o (angle_counts_o),
    .rate_o         (rate_o),
    .status_o       (status_o)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  import eare_pkg::*;

  localparam int  TS_W        = TIME_BITS_DEF;
  localparam int  FRAC        = RATE_FRAC_BITS_DEF;
  localparam bit  OP_INIT     = 1'b0;
  localparam bit  OP_UPDATE   = 1'b1;
  localparam int  STALL_LIMIT = 20000;
  localparam int  LONG_HOLD   = 1000;
  localparam logic [TS_W-1:0] TS_TOP = '1;

  typedef struct {
    bit                       op;
    logic signed [CNT_W-1:0]  count;
    logic [TS_W-1:0]          ts;
  } motion_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [RATE_W-1:0]  rate;
    logic [STATUS_W-1:0]       status;
  } reading_t;

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic                      op_i        = 1'b0;
  logic signed [CNT_W-1:0]   count_i     = '0;
  logic [TS_W-1:0]           timestamp_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [ANGLE_W-1:0] angle_counts_o;
  logic signed [RATE_W-1:0]  rate_o;
  logic [STATUS_W-1:0]       status_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i  = '0;

  encoder_angle_rate_estimator dut (.*);

  // predictor copy of registers and state
  logic [CPR_W-1:0]        cfg_cpr     = CPR_RESET;
  logic [GAIN_W-1:0]       cfg_gain    = GAIN_RESET;
  logic signed [CNT_W-1:0] cfg_upright = '0;
  bit                      est_ready   = 1'b0;
  longint                  est_angle   = 0;
  logic [TS_W-1:0]         est_time    = '0;
  longint                  est_rate    = 0;

  motion_t  samples_q[$];
  reading_t readings_q[$];
  motion_t  drive_item;
  int       n_sent = 0, n_taken = 0, n_bad = 0;
  int       send_idle = 0, stall_pct = 0;
  int       hold_req = 0, hold_served = 0, hold_left = 0;
  int       quiet = 0;
  bit       in_fire = 1'b0;

  logic signed [CNT_W-1:0] gen_count;
  logic [TS_W-1:0]         gen_ts;
  bit                      gen_live;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint wrap_turn(longint d);
    longint m, h, w;
    m = longint'(cfg_cpr);
    if (m == 0) m = 1;
    if (m > longint'(CPR_MAX)) m = longint'(CPR_MAX);
    h = m / 2;
    w = d % m;
    if (w >= h) w -= m;
    else if (w < -h) w += m;
    return w;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic reading_t predict_reading(bit op, logic signed [CNT_W-1:0] cnt,
                                               logic [TS_W-1:0] ts);
    reading_t        r;
    longint          ang, dlt, raw, g;
    longint unsigned dt;
    r.angle  = '0;
    r.rate   = '0;
    r.status = STATUS_OK;
    ang = wrap_turn(longint'(cnt) - longint'(cfg_upright));
    if (op == OP_INIT) begin
      est_angle = ang;
      est_time  = ts;
      est_rate  = 0;
      est_ready = 1'b1;
      r.angle   = ANGLE_W'(ang);
    end else if (!est_ready) begin
      r.status = STATUS_NOT_INIT;
    end else if (ts <= est_time) begin
      r.status = STATUS_BAD_STEP;
    end else begin
      dt  = ts - est_time;
      dlt = wrap_turn(ang - est_angle);
      raw = round_div(dlt * (longint'(1) << FRAC), dt);
      if (raw > (longint'(1) << (RATE_W - 1)) - 1) raw = (longint'(1) << (RATE_W - 1)) - 1;
      if (raw < -(longint'(1) << (RATE_W - 1))) raw = -(longint'(1) << (RATE_W - 1));
      g = (cfg_gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(cfg_gain);
      est_rate  = est_rate + round_div((raw - est_rate) * g, longint'(GAIN_ONE));
      est_angle = ang;
      est_time  = ts;
      r.angle   = ANGLE_W'(ang);
      r.rate    = RATE_W'(est_rate);
    end
    return r;
  endfunction

  task automatic report_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      if (n_bad < 10) $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      n_bad++;
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (samples_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        drive_item = samples_q.pop_front();
        op_i        <= drive_item.op;
        count_i     <= drive_item.count;
        timestamp_i <= drive_item.ts;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver; a long hold lets the block back up into its input
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_served) begin
      hold_served <= hold_req;
      hold_left   <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: register writes, accepted items, results
  always @(posedge clk_i) begin
    reading_t want;
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CPR:     cfg_cpr     = cfg_data_i[CPR_W-1:0];
          CFG_GAIN:    cfg_gain    = cfg_data_i[GAIN_W-1:0];
          CFG_UPRIGHT: cfg_upright = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        readings_q.push_back(predict_reading(op_i, count_i, timestamp_i));
        n_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (readings_q.size() == 0) begin
          if (n_bad < 10) $display("result with no item pending: angle %0d rate %0d status %0d",
                                   angle_counts_o, rate_o, status_o);
          n_bad++;
        end else begin
          want = readings_q.pop_front();
          report_field("angle_counts", want.angle, angle_counts_o);
          report_field("rate", want.rate, rate_o);
          report_field("status", {62'd0, want.status}, {62'd0, status_o});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_item(bit op, logic signed [CNT_W-1:0] cnt, logic [TS_W-1:0] ts);
    motion_t m;
    m.op    = op;
    m.count = cnt;
    m.ts    = ts;
    samples_q.push_back(m);
    n_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // every item answers once, so the block is idle when the last answer is in
  task automatic settle();
    while (n_taken != n_sent || readings_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic restart_track();
    gen_count = $urandom;
    if ($urandom_range(99) < 30) gen_ts = TS_W'({$urandom, $urandom});
    else gen_ts = $urandom_range(0, 1000);
    gen_live = 1'b1;
    push_item(OP_INIT, gen_count, gen_ts);
  endtask

  // mostly plausible motion tracks; some wild counts, bad steps and re-inits
  task automatic gen_segment(int n);
    int            k, pick, span, d;
    logic [TS_W-1:0] step;
    logic [TS_W:0]   nxt;
    gen_live = 1'b0;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (!gen_live || pick < 4) begin
        restart_track();
      end else if (pick < 9) begin
        push_item(OP_UPDATE, $urandom, (gen_ts > 3) ? gen_ts - $urandom_range(0, 3) : gen_ts);
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) step = $urandom_range(1, 64);
        else if (pick < 85) step = $urandom_range(65, 1 << 20);
        else if (pick < 95) step = {16'd0, $urandom};
        else step = TS_W'({$urandom, $urandom});
        if (step == 0) step = 1;
        nxt = gen_ts + step;
        if (nxt[TS_W]) begin
          restart_track();
        end else begin
          pick = $urandom_range(99);
          if (pick < 10) begin
            gen_count = $urandom;
          end else begin
            span = (pick < 60) ? 50 : (pick < 85) ? 5000 : 20000000;
            d = int'($urandom_range(0, 2 * span)) - span;
            gen_count = gen_count + d;
          end
          gen_ts = nxt[TS_W-1:0];
          push_item(OP_UPDATE, gen_count, gen_ts);
        end
      end
    end
  endtask

  task automatic random_config();
    case ($urandom_range(5))
      0: write_reg(CFG_CPR, $urandom_range(1, 16));
      1: write_reg(CFG_CPR, 4096);
      2: write_reg(CFG_CPR, $urandom_range(1, 1 << 24));
      3: write_reg(CFG_CPR, 1 << 24);
      4: write_reg(CFG_CPR, $urandom);
      default: write_reg(CFG_CPR, $urandom_range(17, 5000));
    endcase
    case ($urandom_range(3))
      0: write_reg(CFG_GAIN, GAIN_ONE);
      1: write_reg(CFG_GAIN, $urandom_range(1, 65536));
      2: write_reg(CFG_GAIN, $urandom_range(0, 131071));
      default: write_reg(CFG_GAIN, GAIN_RESET);
    endcase
    write_reg(CFG_UPRIGHT, $urandom);
  endtask

  initial begin : stimulus
    int p, s;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: updates before any init, then steps around an init
    push_item(OP_UPDATE, 32'h7FFF_FFFF, TS_TOP);
    push_item(OP_UPDATE, 32'h8000_0000, '0);
    push_item(OP_INIT, 0, '0);
    push_item(OP_UPDATE, 0, '0);
    push_item(OP_UPDATE, 100, 10);
    push_item(OP_UPDATE, -2048, 11);
    push_item(OP_UPDATE, 32'h7FFF_FFFF, 12);
    push_item(OP_UPDATE, 32'h8000_0000, 13);
    push_item(OP_UPDATE, 2047, TS_TOP);
    push_item(OP_UPDATE, 5, TS_TOP - 1);
    push_item(OP_INIT, 2048, TS_TOP);
    push_item(OP_UPDATE, 0, TS_TOP);
    settle();

    // zero modulus, gain above one, most negative upright
    write_reg(CFG_CPR, 0);
    write_reg(CFG_GAIN, 32'hFFFF_FFFF);
    write_reg(CFG_UPRIGHT, 32'h8000_0000);
    push_item(OP_INIT, 5, 100);
    push_item(OP_UPDATE, -7, 101);
    push_item(OP_UPDATE, 32'h7FFF_FFFF, 103);
    settle();

    // modulus one, gain zero holds the rate
    write_reg(CFG_CPR, 1);
    write_reg(CFG_GAIN, 0);
    write_reg(CFG_UPRIGHT, 32'h7FFF_FFFF);
    push_item(OP_INIT, 0, 0);
    push_item(OP_UPDATE, 12345, 1);
    push_item(OP_UPDATE, -1, 2);
    settle();

    // modulus above the top saturates, unity gain, full half-turn steps
    write_reg(CFG_CPR, 32'hFFFF_FFFF);
    write_reg(CFG_GAIN, GAIN_ONE);
    write_reg(CFG_UPRIGHT, 32'hFFFF_FFFF);
    push_item(OP_INIT, 32'h8000_0000, 0);
    push_item(OP_UPDATE, 32'h0080_0000, 1);
    push_item(OP_UPDATE, 32'h7FFF_FFFF, 2);
    push_item(OP_UPDATE, 32'hFF80_0000, 3);
    settle();

    write_reg(CFG_CPR, CPR_MAX);
    write_reg(CFG_GAIN, 1);
    push_item(OP_INIT, 0, 5);
    push_item(OP_UPDATE, 8388607, 6);
    push_item(OP_UPDATE, -8388608, 7);
    settle();

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 80; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 80; end
        default: begin send_idle = 12; stall_pct = 12; end
      endcase
      for (s = 0; s < 2; s++) begin
        random_config();
        if (p == 0 && s == 0) hold_req++;
        gen_segment(163);
        settle();
      end
    end

    repeat (200) @(posedge clk_i);
    n_bad = n_bad + readings_q.size();
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
